// File: rtl/stpt_pkg.sv
package stpt_pkg;

    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam int PosW = 40;
    localparam int TmpW = 26;
    localparam int TolW = 16;
    localparam int RevW = 32;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 40;

    localparam logic [1:0] ACT_OBSERVE = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [CfgIdxW-1:0] CFG_MAX_POS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_TMP = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_MAX_TMP = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_TOL = 2'd3;

    typedef struct packed {
        logic [1:0]      action;
        logic [PosW-1:0] point_position;
        logic [TmpW-1:0] point_tempo;
        logic [PosW-1:0] span_begin;
        logic [PosW-1:0] span_end;
        logic [PosW-1:0] gap_limit;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic            covered;
        logic            hole_found;
        logic [PosW-1:0] hole_begin;
        logic [PosW-1:0] hole_end;
        logic [RevW-1:0] revision;
        logic [6:0]      entry_count;
    } t_out_item;

endpackage

// File: rtl/stpt_ram.sv
module stpt_ram #(
    parameter int Depth = 64,
    parameter int Width = 66
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/sorted_tempo_point_table_top.sv
// An observe walks the table until it meets a matching entry or the insert point; an insert
// then shifts the tail up one entry at a time. A query walks all used entries. One
// transaction is handled at a time, and the single memory read port paces every walk.
// Reset loads the register defaults and clears count and revision; table contents are unknown.
// The receiver cannot stall: o_done pulses for one cycle with the result.
module sorted_tempo_point_table_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  stpt_pkg::t_in_item                  i_item,
    output logic                                o_done,
    output stpt_pkg::t_out_item                 o_item,
    input  logic                                i_cfg_we,
    input  logic [stpt_pkg::CfgIdxW-1:0]        i_cfg_idx,
    input  logic [stpt_pkg::CfgDataW-1:0]       i_cfg_data
);
    import stpt_pkg::*;

    // One-hot sequencer states.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_QUERY = 6'b001000,
        S_WRITE = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;
    t_in_item r_in;
    logic [PosW-1:0] r_max_pos;
    logic [TmpW-1:0] r_min_tmp, r_max_tmp;
    logic [TolW-1:0] r_tol;
    logic [CntW-1:0] r_used;
    logic [RevW-1:0] r_rev;
    logic [CntW-1:0] r_ptr;     // address issued in the previous cycle
    logic            r_rvalid;  // in S_SHIFT, read data of entry r_ptr-1 is present
    logic [IdxW-1:0] r_ins;     // insert index
    logic [PosW-1:0] r_prev;
    logic            r_have_prev;
    logic            r_cov_bad, r_hole, r_first;
    logic [PosW-1:0] r_hb, r_he;

    logic                 ram_we;
    logic [IdxW-1:0]      ram_waddr, ram_raddr;
    logic [PosW+TmpW-1:0] ram_wdata, ram_rdata;
    logic [PosW-1:0]      rd_pos;
    logic [TmpW-1:0]      rd_tmp;

    stpt_ram #(.Depth(TableDepth), .Width(PosW + TmpW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_pos = ram_rdata[PosW+TmpW-1:TmpW];
    assign rd_tmp = ram_rdata[TmpW-1:0];
    assign busy = (r_state != S_IDLE);

    // Configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pos <= '1;
            r_min_tmp <= TmpW'(65536);
            r_max_tmp <= TmpW'(65470464);
            r_tol     <= TolW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_POS: r_max_pos <= i_cfg_data;
                CFG_MIN_TMP: r_min_tmp <= i_cfg_data[TmpW-1:0];
                CFG_MAX_TMP: r_max_tmp <= i_cfg_data[TmpW-1:0];
                CFG_TOL:     r_tol <= i_cfg_data[TolW-1:0];
                default: ;
            endcase
        end
    end

    logic [PosW:0] sum_tol;
    logic [PosW-1:0] adiff;
    logic [PosW-1:0] gap;
    logic [PosW-1:0] q_b, q_e, q_g;
    logic span_ok;
    logic last_rd;

    assign sum_tol = {1'b0, rd_pos} + {{(PosW+1-TolW){1'b0}}, r_tol};
    assign adiff = (rd_pos > r_in.point_position) ? rd_pos - r_in.point_position
                                                  : r_in.point_position - rd_pos;
    assign gap = rd_pos - r_prev;
    assign q_b = r_in.span_begin;
    assign q_e = r_in.span_end;
    assign q_g = r_in.gap_limit;
    assign span_ok = q_e > q_b;
    assign last_rd = (r_ptr == r_used - CntW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_used   <= '0;
            r_rev    <= '0;
            o_done   <= 1'b0;
            r_rvalid <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_rvalid <= 1'b0;
                    if (start) begin
                        r_in        <= i_item;
                        r_ptr       <= '0;
                        r_have_prev <= 1'b0;
                        r_cov_bad   <= 1'b0;
                        r_hole      <= 1'b0;
                        r_first     <= 1'b1;
                        r_hb        <= '0;
                        r_he        <= '0;
                        o_item      <= '0;
                        case (i_item.action)
                            ACT_OBSERVE: begin
                                if (i_item.point_position > r_max_pos
                                    || i_item.point_tempo < r_min_tmp
                                    || i_item.point_tempo > r_max_tmp) begin
                                    o_item.status <= ST_RANGE;
                                    r_state <= S_DONE;
                                end else if (r_used == '0) begin
                                    r_ins   <= '0;
                                    r_state <= S_WRITE;
                                end else begin
                                    r_rvalid <= 1'b1;
                                    r_state  <= S_SCAN;
                                end
                            end
                            ACT_QUERY: begin
                                if (r_used == '0) begin
                                    r_state <= S_DONE;
                                    o_item.covered <= 1'b0;
                                    o_item.hole_found <= i_item.span_end > i_item.span_begin;
                                    if (i_item.span_end > i_item.span_begin) begin
                                        o_item.hole_begin <= i_item.span_begin;
                                        o_item.hole_end   <= i_item.span_end;
                                    end
                                end else begin
                                    r_rvalid <= 1'b1;
                                    r_state  <= S_QUERY;
                                end
                            end
                            ACT_CLEAR: begin
                                if (r_used != '0) r_rev <= r_rev + RevW'(1);
                                r_used  <= '0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    // rd_pos is entry r_ptr.
                    if (sum_tol >= {1'b0, r_in.point_position}) begin
                        if (adiff <= PosW'(r_tol)) begin
                            if (rd_tmp != r_in.point_tempo) r_rev <= r_rev + RevW'(1);
                            // The matched entry keeps its stored position.
                            r_in.point_position <= rd_pos;
                            r_ins   <= r_ptr[IdxW-1:0];
                            r_state <= S_WRITE;
                            r_first <= 1'b0; // update in place
                        end else if (r_used == CntW'(TableDepth)) begin
                            o_item.status <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_ins <= r_ptr[IdxW-1:0];
                            r_ptr <= r_used;
                            r_rvalid <= 1'b0;
                            r_state <= S_SHIFT;
                        end
                    end else if (last_rd) begin
                        if (r_used == CntW'(TableDepth)) begin
                            o_item.status <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_ins   <= r_used[IdxW-1:0];
                            r_state <= S_WRITE;
                        end
                    end else begin
                        r_ptr <= r_ptr + CntW'(1);
                    end
                end
                S_SHIFT: begin
                    // Copy entry r_ptr-1 to r_ptr, reading it in the cycle before the write.
                    if (r_rvalid) begin
                        r_ptr <= r_ptr - CntW'(1);
                        if (r_ptr - CntW'(1) == {1'b0, r_ins}) r_state <= S_WRITE;
                    end
                    r_rvalid <= ~r_rvalid;
                end
                S_QUERY: begin
                    r_prev <= rd_pos;
                    r_have_prev <= 1'b1;
                    if (!r_have_prev) begin
                        if (rd_pos > q_b) begin
                            r_cov_bad <= 1'b1;
                            if (span_ok && !r_hole) begin
                                r_hole <= 1'b1;
                                r_hb <= q_b;
                                r_he <= (rd_pos < q_e) ? rd_pos : q_e;
                            end
                        end
                    end else if (gap > q_g) begin
                        r_cov_bad <= 1'b1;
                        if (span_ok && !r_hole && q_g != '0 && rd_pos > q_b && r_prev < q_e) begin
                            r_hole <= 1'b1;
                            r_hb <= (r_prev > q_b) ? r_prev : q_b;
                            r_he <= (rd_pos < q_e) ? rd_pos : q_e;
                        end
                    end
                    if (last_rd) begin
                        r_state <= S_DONE;
                        o_item.covered <= span_ok && q_g != '0 && rd_pos >= q_e && !r_cov_bad
                                          && !(!r_have_prev && rd_pos > q_b)
                                          && !(r_have_prev && gap > q_g);
                        if (r_hole) begin
                            o_item.hole_found <= 1'b1;
                            o_item.hole_begin <= r_hb;
                            o_item.hole_end <= r_he;
                        end else if (!r_have_prev && rd_pos > q_b && span_ok) begin
                            o_item.hole_found <= 1'b1;
                            o_item.hole_begin <= q_b;
                            o_item.hole_end <= (rd_pos < q_e) ? rd_pos : q_e;
                        end else if (r_have_prev && gap > q_g && span_ok && q_g != '0
                                     && rd_pos > q_b && r_prev < q_e) begin
                            o_item.hole_found <= 1'b1;
                            o_item.hole_begin <= (r_prev > q_b) ? r_prev : q_b;
                            o_item.hole_end <= (rd_pos < q_e) ? rd_pos : q_e;
                        end else if (span_ok && rd_pos < q_e) begin
                            o_item.hole_found <= 1'b1;
                            o_item.hole_begin <= (rd_pos > q_b) ? rd_pos : q_b;
                            o_item.hole_end <= q_e;
                        end
                    end else begin
                        r_ptr <= r_ptr + CntW'(1);
                    end
                end
                S_WRITE: begin
                    if (r_first) begin
                        r_used <= r_used + CntW'(1);
                        r_rev  <= r_rev + RevW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    o_done <= 1'b1;
                    o_item.revision <= r_rev;
                    o_item.entry_count <= 7'(r_used);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Memory port control.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_ins;
        ram_wdata = {r_in.point_position, r_in.point_tempo};
        ram_raddr = '0;
        case (r_state)
            S_IDLE:  ram_raddr = '0;
            S_SCAN, S_QUERY: ram_raddr = r_ptr[IdxW-1:0] + IdxW'(1);
            S_SHIFT: begin
                ram_raddr = r_ptr[IdxW-1:0] - IdxW'(1);
                if (r_rvalid) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_ptr[IdxW-1:0];
                    ram_wdata = ram_rdata;
                end
            end
            S_WRITE: ram_we = 1'b1;
            default: ;
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CntW'(TableDepth))
        else $error("entry count exceeds table depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == S_DONE)
        else $error("result without completion");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && start) |=> busy)
        else $error("transaction not taken");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WRITE || r_state == S_SHIFT))
        else $error("unexpected table write");
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import stpt_pkg::*;

    localparam logic [1:0] ActUnused = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    t_in_item            in_item;
    logic                done;
    t_out_item           out_item;
    logic                cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    sorted_tempo_point_table_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (in_item),
        .o_done     (done),
        .o_item     (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // The predictor keeps its own copy of the table and the registers.
    logic [PosW-1:0] lim_pos;
    logic [TmpW-1:0] lim_tmp_lo;
    logic [TmpW-1:0] lim_tmp_hi;
    logic [TolW-1:0] tol;
    logic [PosW-1:0] tbl_pos [TableDepth];
    logic [TmpW-1:0] tbl_tmp [TableDepth];
    int              tbl_used;
    logic [RevW-1:0] tbl_rev;

    t_out_item expected_results[$];
    int        error_count;
    int        sender_idle_pct;

    always #5 clk = ~clk;

    // Every mismatch goes through here so that the count stays in one place.
    task automatic report_error(input string what);
        error_count++;
        $display("ERROR %0t: %s", $realtime, what);
    endtask

    // Observe: range check, then match within tolerance or insert in order.
    function automatic logic [1:0] table_observe(input logic [PosW-1:0] p,
                                                 input logic [TmpW-1:0] t);
        int idx;
        logic [PosW:0] reach;
        logic [PosW-1:0] diff;
        idx = 0;
        if (p > lim_pos || t < lim_tmp_lo || t > lim_tmp_hi) return ST_RANGE;
        // The sum is taken one bit wider so that it cannot wrap.
        while (idx < tbl_used) begin
            reach = {1'b0, tbl_pos[idx]} + {{(PosW+1-TolW){1'b0}}, tol};
            if (reach >= {1'b0, p}) break;
            idx++;
        end
        if (idx < tbl_used) begin
            diff = (tbl_pos[idx] > p) ? tbl_pos[idx] - p : p - tbl_pos[idx];
            if (diff <= PosW'(tol)) begin
                if (tbl_tmp[idx] != t) begin
                    tbl_tmp[idx] = t;
                    tbl_rev++;
                end
                return ST_OK;
            end
        end
        if (tbl_used >= TableDepth) return ST_FULL;
        for (int k = tbl_used; k > idx; k--) begin
            tbl_pos[k] = tbl_pos[k-1];
            tbl_tmp[k] = tbl_tmp[k-1];
        end
        tbl_pos[idx] = p;
        tbl_tmp[idx] = t;
        tbl_used++;
        tbl_rev++;
        return ST_OK;
    endfunction

    // Query: coverage flag plus the first uncovered sub-span.
    function automatic void table_query(input logic [PosW-1:0] b, input logic [PosW-1:0] e,
                                        input logic [PosW-1:0] g, inout t_out_item r);
        logic [PosW-1:0] prv;
        logic [PosW-1:0] nxt;
        logic [PosW-1:0] last;
        r.covered = 1'b0;
        if (tbl_used != 0 && g != 0 && e > b && tbl_pos[0] <= b
                && tbl_pos[tbl_used-1] >= e) begin
            r.covered = 1'b1;
            for (int k = 1; k < tbl_used; k++)
                if (tbl_pos[k] - tbl_pos[k-1] > g) r.covered = 1'b0;
        end
        if (e <= b) return;
        if (tbl_used == 0) begin
            r.hole_found = 1'b1; r.hole_begin = b; r.hole_end = e;
            return;
        end
        if (tbl_pos[0] > b) begin
            r.hole_found = 1'b1; r.hole_begin = b;
            r.hole_end = (tbl_pos[0] < e) ? tbl_pos[0] : e;
            return;
        end
        if (g != 0) begin
            for (int k = 1; k < tbl_used; k++) begin
                prv = tbl_pos[k-1];
                nxt = tbl_pos[k];
                if (nxt - prv <= g || nxt <= b || prv >= e) continue;
                r.hole_found = 1'b1;
                r.hole_begin = (prv > b) ? prv : b;
                r.hole_end = (nxt < e) ? nxt : e;
                return;
            end
        end
        last = tbl_pos[tbl_used-1];
        if (last < e) begin
            r.hole_found = 1'b1; r.hole_begin = (last > b) ? last : b; r.hole_end = e;
        end
    endfunction

    function automatic t_out_item table_step(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.action)
            ACT_OBSERVE: begin
                r.status = table_observe(it.point_position, it.point_tempo);
            end
            ACT_QUERY: begin
                table_query(it.span_begin, it.span_end, it.gap_limit, r);
            end
            ACT_CLEAR: begin
                if (tbl_used != 0) tbl_rev++;
                tbl_used = 0;
            end
            default: ;
        endcase
        r.revision = tbl_rev;
        r.entry_count = 7'(tbl_used);
        return r;
    endfunction

    // Results are sampled at the edge that ends their strobe cycle.
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && done) begin
            if (expected_results.size() == 0) begin
                report_error("result with nothing expected");
            end else begin
                want = expected_results.pop_front();
                if (out_item.status !== want.status)
                    report_error($sformatf("status %0d, want %0d", out_item.status,
                                           want.status));
                if (out_item.covered !== want.covered)
                    report_error($sformatf("covered %0b, want %0b", out_item.covered,
                                           want.covered));
                if (out_item.hole_found !== want.hole_found)
                    report_error($sformatf("hole_found %0b, want %0b",
                                           out_item.hole_found, want.hole_found));
                if (out_item.hole_begin !== want.hole_begin)
                    report_error($sformatf("hole_begin %0h, want %0h",
                                           out_item.hole_begin, want.hole_begin));
                if (out_item.hole_end !== want.hole_end)
                    report_error($sformatf("hole_end %0h, want %0h", out_item.hole_end,
                                           want.hole_end));
                if (out_item.revision !== want.revision)
                    report_error($sformatf("revision %0d, want %0d", out_item.revision,
                                           want.revision));
                if (out_item.entry_count !== want.entry_count)
                    report_error($sformatf("entry_count %0d, want %0d",
                                           out_item.entry_count, want.entry_count));
            end
        end
    end

    // Sends one transaction. Start stays high until an edge with busy low
    // takes it; the prediction is made at that same edge. Start is low for
    // the following cycle, while the block is busy anyway.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
        start   <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_results.push_back(table_step(it));
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Waits for every result, then lets the walk of an item finish.
    task automatic drain_results();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (2 * TableDepth + 10) @(posedge clk);
    endtask

    task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_POS: lim_pos    = v[PosW-1:0];
            CFG_MIN_TMP: lim_tmp_lo = v[TmpW-1:0];
            CFG_MAX_TMP: lim_tmp_hi = v[TmpW-1:0];
            default:     tol        = v[TolW-1:0];
        endcase
        @(posedge clk);
    endtask

    function automatic t_in_item make_item(input logic [1:0] act);
        t_in_item it;
        logic [191:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = rnd[$bits(t_in_item)-1:0];
        it.action = act;
        return it;
    endfunction

    function automatic t_in_item observe_item(input logic [PosW-1:0] p,
                                              input logic [TmpW-1:0] t);
        t_in_item it;
        it = make_item(ACT_OBSERVE);
        it.point_position = p;
        it.point_tempo = t;
        return it;
    endfunction

    function automatic t_in_item query_item(input logic [PosW-1:0] b, input logic [PosW-1:0] e,
                                            input logic [PosW-1:0] g);
        t_in_item it;
        it = make_item(ACT_QUERY);
        it.span_begin = b;
        it.span_end = e;
        it.gap_limit = g;
        return it;
    endfunction

    // Directed: field extremes, every action, tolerance match with and
    // without a tempo change, a full table, and holes in an empty table and between entries.
    task automatic test_directed();
        send_item(make_item(ACT_CLEAR));
        send_item(query_item(40'd0, 40'd100, 40'd10));
        send_item(query_item(40'd100, 40'd100, 40'd10));
        send_item(observe_item(40'd1000, 26'd65536));
        send_item(observe_item(40'd1001, 26'd65536));
        send_item(observe_item(40'd999, 26'd70000));
        send_item(observe_item(40'd5000, 26'd65470464));
        send_item(observe_item(40'd3000, 26'd65535));
        send_item(observe_item(40'd3000, 26'd65470465));
        send_item(observe_item('1, '1));
        send_item(observe_item('1, 26'd100000));
        send_item(observe_item(40'd0, 26'd100000));
        send_item(query_item(40'd0, 40'd5000, 40'd3000));
        send_item(query_item(40'd0, 40'd5000, 40'd0));
        send_item(query_item(40'd0, 40'd5000, 40'd100));
        send_item(query_item(40'd500, 40'd9000, '1));
        send_item(query_item(40'd0, '1, '1));
        send_item(query_item('1, 40'd0, 40'd1));
        send_item(make_item(ActUnused));
        send_item(make_item(ACT_CLEAR));
        send_item(make_item(ACT_CLEAR));
        for (int k = 0; k < TableDepth + 2; k++)
            send_item(observe_item(40'(k * 100 + 50), 26'd120000));
        send_item(make_item(ACT_CLEAR));
    endtask

    // Random: most observes fall in the window 0..pos_span so that matches, inserts
    // and a full table can happen; queries mostly use spans in the same window.
    task automatic test_random(input int count, input int pos_span);
        t_in_item it;
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 55) begin
                it = make_item(ACT_OBSERVE);
                if ($urandom_range(9) != 0) begin
                    it.point_position = 40'($urandom_range(pos_span));
                    it.point_tempo = 26'($urandom_range(lim_tmp_hi, lim_tmp_lo));
                end
            end else if (sel < 90) begin
                it = make_item(ACT_QUERY);
                if ($urandom_range(7) != 0) begin
                    it.span_begin = 40'($urandom_range(pos_span));
                    it.span_end = 40'($urandom_range(pos_span));
                    it.gap_limit = 40'($urandom_range(pos_span / 4));
                end
            end else if (sel < 97) begin
                it = make_item(ACT_CLEAR);
            end else begin
                it = make_item(ActUnused);
            end
            send_item(it);
        end
    endtask

    task automatic test_config_sweep();
        drain_results();
        write_register(CFG_MAX_POS, 40'd3000);
        write_register(CFG_MIN_TMP, 40'd0);
        write_register(CFG_MAX_TMP, '1);
        write_register(CFG_TOL, 40'd0);
        test_random(200, 4000);
        drain_results();
        write_register(CFG_TOL, 40'hFFFF);
        write_register(CFG_MAX_POS, 40'd0);
        test_random(100, 400000);
        drain_results();
        write_register(CFG_MAX_POS, '1);
        write_register(CFG_MIN_TMP, 40'd1000);
        write_register(CFG_MAX_TMP, 40'd2000);
        write_register(CFG_TOL, 40'd25);
        test_random(200, 20000);
        drain_results();
        write_register(CFG_MIN_TMP, 40'd65536);
        write_register(CFG_MAX_TMP, 40'd65470464);
        write_register(CFG_TOL, 40'd1);
    endtask

    initial begin
        clk = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        in_item = '0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        error_count = 0;
        sender_idle_pct = 0;
        lim_pos = '1;
        lim_tmp_lo = 26'd65536;
        lim_tmp_hi = 26'd65470464;
        tol = 16'd1;
        tbl_used = 0;
        tbl_rev = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(400, 6000);
        sender_idle_pct = 82;
        test_random(250, 6000);
        // Hold off the sender until the table has answered everything.
        drain_results();
        sender_idle_pct = 26;
        test_random(250, 6000);
        sender_idle_pct = 0;
        test_config_sweep();
        test_random(350, 1000000);

        drain_results();
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

endmodule

// File: sorted_tempo_point_table_top.f
rtl/stpt_pkg.sv
rtl/stpt_ram.sv
rtl/sorted_tempo_point_table_top.sv
tb/sv/testbench.sv
